// File: rtl/core/base64_stream_encoder_core_macros.svh
// Assertion helpers shared by the core
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication
`define B64E_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("base64 encoder core: assertion failed");

// Next-cycle implication
`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("base64 encoder core: assertion failed");

`endif

// File: rtl/core/b64e_pkg.sv
package b64e_pkg;

    localparam int CHAR_W   = 7;
    localparam int MAX_CHAR = 4;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_OFS = 7'h47;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_OFS = 7'h04;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;
    localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;
    localparam logic [CHAR_W-1:0] CHAR_MIN   = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MAX   = 7'h7A;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_62    = 6'd62;

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    typedef struct packed {
        logic [MAX_CHAR-1:0][CHAR_W-1:0] chars;
        logic [1:0]                      cnt_m1;
        logic                            last;
    } job_t;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v,
                                                     input logic       url_safe);
        logic [CHAR_W-1:0] vx;
        vx = CHAR_W'(v);
        if (v < SEXTET_LOWER) begin
            return CHAR_UPPER_A + vx;
        end else if (v < SEXTET_DIGIT) begin
            return vx + CHAR_LOWER_OFS;
        end else if (v < SEXTET_62) begin
            return vx - CHAR_DIGIT_OFS;
        end else if (v == SEXTET_62) begin
            return url_safe ? CHAR_DASH : CHAR_PLUS;
        end else begin
            return url_safe ? CHAR_UNDER : CHAR_SLASH;
        end
    endfunction

endpackage

// File: rtl/core/b64e_front.sv
module b64e_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_last_byte,
    input  logic           url_safe,
    output logic           push_valid,
    input  logic           push_ready,
    output b64e_pkg::job_t push_job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    job_t       job;
    logic       take;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign push_job   = job;
    assign take       = s_valid && push_ready;

    always_comb begin
        job        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        job.last   = s_last_byte;
        unique case (phase_reg)
            PH_1: begin
                job.chars[0] = sextet_char({carry_reg[1:0], s_data_byte[7:4]}, url_safe);
                job.chars[1] = sextet_char({s_data_byte[3:0], 2'b00}, url_safe);
                job.chars[2] = CHAR_PAD;
                job.cnt_m1   = s_last_byte ? 2'd2 : 2'd0;
                phase_next   = PH_2;
            end
            PH_2: begin
                job.chars[0] = sextet_char({carry_reg, s_data_byte[7:6]}, url_safe);
                job.chars[1] = sextet_char(s_data_byte[5:0], url_safe);
                job.cnt_m1   = 2'd1;
                phase_next   = PH_0;
            end
            default: begin
                job.chars[0] = sextet_char(s_data_byte[7:2], url_safe);
                job.chars[1] = sextet_char({s_data_byte[1:0], 4'b0000}, url_safe);
                job.chars[2] = CHAR_PAD;
                job.chars[3] = CHAR_PAD;
                job.cnt_m1   = s_last_byte ? 2'd3 : 2'd0;
                phase_next   = PH_1;
            end
        endcase
        carry_next = s_data_byte[3:0];
        if (s_last_byte) begin
            phase_next = PH_0;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// File: rtl/core/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  b64e_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output b64e_pkg::job_t out_job
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/b64e_back.sv
module b64e_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  b64e_pkg::job_t              q_job,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [b64e_pkg::CHAR_W-1:0] m_char_code,
    output logic                        m_last_char
);
    import b64e_pkg::*;

    job_t              job_reg, job_next;
    logic [1:0]        idx_reg, idx_next;
    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;
    logic              out_free, emit, fin, load;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign fin      = emit && (idx_reg == job_reg.cnt_m1);
    assign q_ready  = !busy_reg || fin;
    assign load     = q_valid && q_ready;

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last_char = m_last_reg;

    always_comb begin
        job_next     = load ? q_job : job_reg;
        busy_next    = load ? 1'b1 : (fin ? 1'b0 : busy_reg);
        idx_next     = load ? 2'd0 : (emit ? idx_reg + 2'd1 : idx_reg);
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_char_next  = emit ? job_reg.chars[idx_reg] : m_char_reg;
        m_last_next  = emit ? (job_reg.last && fin) : m_last_reg;
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        idx_reg    <= idx_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/core/base64_stream_encoder_core.sv
// Streaming Base64 encoder: one raw byte per input transfer, one ASCII character
// per output transfer, with '=' padding and a last-character flag after the byte
// marked last. The front end takes each byte, tracks its place in the 3-byte group
// and queues up to QUEUE_DEPTH character groups; the back end's output register
// issues one character per cycle while groups are queued and m_ready is high. The
// first two bytes of a group give one character each, the third two, and a last
// byte up to four. The first character passes through the queue, the back end's
// job register and its output register. The user must write the alphabet register
// (cfg_data, bit 0 set selects '-' and '_') only while idle; it is not enforced.
`include "base64_stream_encoder_core_macros.svh"

module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [b64e_pkg::CHAR_W-1:0] m_char_code,
    output logic                        m_last_char,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import b64e_pkg::*;

    logic url_safe_reg;
    logic push_valid, push_ready;
    job_t push_job;
    logic q_valid, q_ready;
    job_t q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_safe_reg <= 1'b0;
        end else if (cfg_valid) begin
            url_safe_reg <= cfg_data;
        end
    end

    b64e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .url_safe    (url_safe_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    b64e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_job       (q_job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

    `B64E_ASSERT_NEXT(a_push_seen, aclk, aresetn, s_valid && s_ready, q_valid)
    `B64E_ASSERT_NOW(a_char_range, aclk, aresetn, m_valid,
        (m_char_code >= CHAR_MIN) && (m_char_code <= CHAR_MAX))
    `B64E_ASSERT_NEXT(a_pad_pair, aclk, aresetn,
        m_valid && m_ready && (m_char_code == CHAR_PAD) && !m_last_char,
        m_valid && (m_char_code == CHAR_PAD) && m_last_char)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    import b64e_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_byte_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } glyph_t;

    localparam int STALL_LIMIT = 1000;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [7:0]        s_data_byte = 8'h00;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [CHAR_W-1:0] m_char_code;
    logic              m_last_char;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic              cfg_data    = 1'b0;

    raw_byte_t raw_q[$];
    glyph_t    glyph_q[$];
    raw_byte_t drv_item;
    glyph_t    want_glyph;

    logic       s_acc   = 1'b0;
    logic       cfg_acc = 1'b0;
    bit         steady  = 1'b0;
    int         errors  = 0;
    int         stall_cycles = 0;

    logic [1:0] grp_phase;
    logic [3:0] carry_nib;
    bit         url_mode;

    base64_stream_encoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [CHAR_W-1:0] glyph_of(logic [5:0] v, bit url);
        logic [CHAR_W-1:0] w;
        w = {1'b0, v};
        if (v < 6'd26) return w + 7'h41;
        if (v < 6'd52) return w - 7'd26 + 7'h61;
        if (v < 6'd62) return w - 7'd52 + 7'h30;
        if (v == 6'd62) return url ? CHAR_DASH : CHAR_PLUS;
        return url ? CHAR_UNDER : CHAR_SLASH;
    endfunction

    function automatic void push_glyph(logic [CHAR_W-1:0] code, logic last);
        glyph_q.push_back('{code: code, last: last});
    endfunction

    function automatic void encode_byte(logic [7:0] b, logic lst);
        case (grp_phase)
            2'd1: begin
                push_glyph(glyph_of({carry_nib[1:0], b[7:4]}, url_mode), 1'b0);
                if (lst) begin
                    push_glyph(glyph_of({b[3:0], 2'b00}, url_mode), 1'b0);
                    push_glyph(CHAR_PAD, 1'b1);
                end
                grp_phase = 2'd2;
            end
            2'd2: begin
                push_glyph(glyph_of({carry_nib, b[7:6]}, url_mode), 1'b0);
                push_glyph(glyph_of(b[5:0], url_mode), lst);
                grp_phase = 2'd0;
            end
            default: begin
                push_glyph(glyph_of(b[7:2], url_mode), 1'b0);
                if (lst) begin
                    push_glyph(glyph_of({b[1:0], 4'b0000}, url_mode), 1'b0);
                    push_glyph(CHAR_PAD, 1'b0);
                    push_glyph(CHAR_PAD, 1'b1);
                end
                grp_phase = 2'd1;
            end
        endcase
        carry_nib = b[3:0];
        if (lst) begin
            grp_phase = 2'd0;
            carry_nib = 4'h0;
        end
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("tb: mismatch in %s: got %0h, want %0h at %0t", what, got, want, $time);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_acc) begin
            if (raw_q.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
                drv_item = raw_q.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= drv_item.data;
                s_last_byte <= drv_item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge aclk) begin
        s_acc   <= s_valid && s_ready;
        cfg_acc <= cfg_valid && cfg_ready;
        if (!aresetn) begin
            grp_phase = 2'd0;
            carry_nib = 4'h0;
            url_mode  = 1'b0;
            glyph_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) url_mode = cfg_data;
            if (s_valid && s_ready) encode_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (glyph_q.size() == 0) begin
                    report("unexpected char", m_char_code, 0);
                end else begin
                    want_glyph = glyph_q.pop_front();
                    if (m_char_code !== want_glyph.code)
                        report("char_code", m_char_code, want_glyph.code);
                    if (m_last_char !== want_glyph.last)
                        report("last_char", m_last_char, want_glyph.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] b, logic lst);
        raw_q.push_back('{data: b, last: lst});
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom());
    endfunction

    task automatic drain();
        @(posedge aclk);
        while (raw_q.size() != 0 || s_valid || glyph_q.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        drain();
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_alphabet(bit url);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= url;
        @(negedge aclk);
        while (!cfg_acc) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int total;
        int run_no;
        int budget;
        int cnt;
        int len;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // single-byte messages, both extremes
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // two bytes: sextets 62 and 63
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // full group ending on the last byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // last byte opens a new group
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b1);
        // last byte second in its group
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'hFD, 1'b0);
        queue_byte(8'hFC, 1'b0);
        queue_byte(8'hFB, 1'b1);
        settle();

        write_alphabet(1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        settle();

        total  = 0;
        run_no = 0;
        while (total < 400) begin
            if (run_no == 0) write_alphabet(1'b0);
            else if (run_no == 1) write_alphabet(1'b1);
            else write_alphabet($urandom_range(0, 1));
            steady = (run_no == 2);
            budget = $urandom_range(40, 80);
            cnt = 0;
            while (cnt < budget) begin
                if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 24);
                else len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    queue_byte(rand_byte(), i == len - 1);
                end
                cnt += len;
                if ($urandom_range(0, 9) == 0) drain();
            end
            // leave a message open across the alphabet write
            if ($urandom_range(0, 2) == 0) begin
                queue_byte(rand_byte(), 1'b0);
                cnt++;
            end
            total += cnt;
            settle();
            steady = 1'b0;
            run_no++;
        end

        drain();
        repeat (20) @(negedge aclk);
        if (errors == 0 && glyph_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: base64_stream_encoder_core.f
+incdir+rtl/core
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder_core.sv
bench/tb.sv
